[hdl/twt_pkg.sv]
// Shared types, codes and helpers for the tile wipe transition block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package twt_pkg;

  localparam int FADE_FRAMES_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_IN   = 2'd1;
  localparam logic [1:0] MODE_OUT  = 2'd2;

  localparam logic [2:0] DIR_LEFT    = 3'd0;
  localparam logic [2:0] DIR_UP      = 3'd1;
  localparam logic [2:0] DIR_RIGHT   = 3'd2;
  localparam logic [2:0] DIR_DOWN    = 3'd3;
  localparam logic [2:0] DIR_DIAMOND = 3'd4;

  localparam logic [0:0] REG_WIDTH  = 1'd0;
  localparam logic [0:0] REG_HEIGHT = 1'd1;

  // classified word handed from front to back, with status after the word
  typedef struct packed {
    logic [1:0] kind;
    logic [8:0] tile_x;
    logic [8:0] tile_y;
    logic [1:0] mode;
    logic [2:0] dir;
    logic [8:0] tick;
    logic       full;
  } entry_t;

  // larger screen dimension in whole tiles
  function automatic logic [7:0] max_tiles(input logic [11:0] sw, input logic [11:0] sh);
    logic [11:0] m;
    m = (sw > sh) ? sw : sh;
    return m[11:4];
  endfunction

endpackage

[hdl/twt_queue.sv]
// Small word queue between front and back of the tile wipe block.
// Depends on twt_pkg (entry_t).
`timescale 1ns / 1ps

module twt_queue #(
  parameter int DEPTH = twt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  twt_pkg::entry_t            push_data,
  input  logic                       pop,
  output twt_pkg::entry_t            head,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  twt_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign head  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(DEPTH));
  assign count = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hdl/twt_front.sv]
// Front of the tile wipe block: accepts words, updates the fade state and
// classifies each word into a queue entry. Depends on twt_pkg.
`timescale 1ns / 1ps

module twt_front #(
  parameter int FADE_FRAMES = twt_pkg::FADE_FRAMES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [11:0]     screen_width,
  input  logic [11:0]     screen_height,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_kind,
  input  logic [1:0]      in_start_mode,
  input  logic [2:0]      in_start_dir,
  input  logic [8:0]      in_tile_x,
  input  logic [8:0]      in_tile_y,
  input  logic            q_full,
  output logic            push,
  output twt_pkg::entry_t push_data
);

  logic [1:0] mode_r, mode_nxt;
  logic [2:0] dir_r, dir_nxt;
  logic [8:0] tick_r, tick_nxt;
  logic       mask_r, mask_nxt;
  logic [8:0] tick_inc;
  logic [9:0] frames;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign tick_inc = tick_r + 9'd1;
  assign frames   = {2'b00, twt_pkg::max_tiles(screen_width, screen_height)}
                  + 10'(FADE_FRAMES);

  always_comb begin
    mode_nxt = mode_r;
    dir_nxt  = dir_r;
    tick_nxt = tick_r;
    mask_nxt = mask_r;
    case (in_kind)
      twt_pkg::KIND_START: begin
        if (in_start_mode == twt_pkg::MODE_IN || in_start_mode == twt_pkg::MODE_OUT) begin
          mode_nxt = in_start_mode;
          dir_nxt  = in_start_dir;
          tick_nxt = '0;
          mask_nxt = 1'b0;
        end
      end
      twt_pkg::KIND_TICK: begin
        if (mode_r != twt_pkg::MODE_IDLE) begin
          mask_nxt = 1'b0;
          tick_nxt = tick_inc;
          if ({1'b0, tick_inc} > frames) begin
            mask_nxt = (mode_r == twt_pkg::MODE_OUT);
            mode_nxt = twt_pkg::MODE_IDLE;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    push_data.kind   = in_kind;
    push_data.tile_x = in_tile_x;
    push_data.tile_y = in_tile_y;
    push_data.mode   = mode_nxt;
    push_data.dir    = dir_nxt;
    push_data.tick   = tick_nxt;
    push_data.full   = mask_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= twt_pkg::MODE_IDLE;
      dir_r  <= '0;
      tick_r <= '0;
      mask_r <= 1'b0;
    end else if (push) begin
      mode_r <= mode_nxt;
      dir_r  <= dir_nxt;
      tick_r <= tick_nxt;
      mask_r <= mask_nxt;
    end
  end

endmodule

[hdl/twt_back.sv]
// Back of the tile wipe block: works out overlay frame and draw position
// for the queue head and holds the result word. Depends on twt_pkg.
`timescale 1ns / 1ps

module twt_back #(
  parameter int FADE_FRAMES = twt_pkg::FADE_FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [11:0]        screen_width,
  input  logic [11:0]        screen_height,
  input  logic               q_empty,
  input  twt_pkg::entry_t    head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_tile_drawn,
  output logic [3:0]         out_tile_frame,
  output logic signed [13:0] out_draw_x,
  output logic signed [13:0] out_draw_y,
  output logic               out_mask_full,
  output logic               out_fade_active
);

  localparam int FLIM_I = (FADE_FRAMES - 1 < 15) ? FADE_FRAMES - 1 : 15;
  localparam logic signed [11:0] F_S  = 12'(FADE_FRAMES);
  localparam logic signed [11:0] FLIM = 12'(FLIM_I);

  logic               valid_r;
  logic               drawn_r;
  logic [3:0]         frame_r;
  logic signed [13:0] dx_r, dy_r;
  logic               full_r, active_r;

  logic [8:0]         w_u, h_u;
  logic [6:0]         cx, cy;
  logic [8:0]         adx, ady;
  logic signed [11:0] x_s, y_s, w_s, h_s, c_s, d_s, frames_s, r_s, f, f_cl;
  logic               in_grid, drawn;
  logic [3:0]         frame_w;
  logic signed [13:0] dx_w, dy_w;

  assign pop = !q_empty && (!valid_r || out_ready);

  always_comb begin
    w_u      = {1'b0, screen_width[11:4]} + 9'd1;
    h_u      = {1'b0, screen_height[11:4]} + 9'd1;
    cx       = screen_width[11:5];
    cy       = screen_height[11:5];
    adx      = (head.tile_x > {2'b00, cx}) ? head.tile_x - {2'b00, cx}
                                           : {2'b00, cx} - head.tile_x;
    ady      = (head.tile_y > {2'b00, cy}) ? head.tile_y - {2'b00, cy}
                                           : {2'b00, cy} - head.tile_y;
    x_s      = $signed({3'b000, head.tile_x});
    y_s      = $signed({3'b000, head.tile_y});
    w_s      = $signed({3'b000, w_u});
    h_s      = $signed({3'b000, h_u});
    c_s      = $signed({3'b000, head.tick});
    d_s      = $signed({2'b00, {1'b0, adx} + {1'b0, ady}});
    frames_s = $signed({4'b0000, twt_pkg::max_tiles(screen_width, screen_height)}) + F_S;
    r_s      = frames_s - c_s;
    in_grid  = (head.tile_x < w_u) && (head.tile_y < h_u);
    f        = '0;
    if (head.kind == twt_pkg::KIND_QUERY && !head.full && in_grid) begin
      if (head.mode == twt_pkg::MODE_IN) begin
        case (head.dir)
          twt_pkg::DIR_LEFT:    f = r_s - x_s;
          twt_pkg::DIR_UP:      f = r_s - y_s;
          twt_pkg::DIR_RIGHT:   f = x_s - (w_s - r_s);
          twt_pkg::DIR_DOWN:    f = y_s - (h_s - r_s);
          twt_pkg::DIR_DIAMOND: f = F_S - (c_s - d_s);
          default:              f = '0;
        endcase
      end else if (head.mode == twt_pkg::MODE_OUT) begin
        case (head.dir)
          twt_pkg::DIR_LEFT:    f = x_s - (w_s - c_s);
          twt_pkg::DIR_UP:      f = y_s - (h_s - c_s);
          twt_pkg::DIR_RIGHT:   f = c_s - x_s;
          twt_pkg::DIR_DOWN:    f = c_s - y_s;
          twt_pkg::DIR_DIAMOND: f = F_S - (r_s - d_s);
          default:              f = '0;
        endcase
      end
    end
    drawn   = (f > 12'sd0);
    f_cl    = (f > FLIM) ? FLIM : f;
    frame_w = drawn ? f_cl[3:0] : 4'd0;
    // w*16 - width reduces to 16 - (width mod 16)
    dx_w    = drawn ? $signed({1'b0, head.tile_x, 4'b0000} - 14'd16
                              + {10'd0, screen_width[3:0]}) : 14'sd0;
    dy_w    = drawn ? $signed({1'b0, head.tile_y, 4'b0000} - 14'd16
                              + {10'd0, screen_height[3:0]}) : 14'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      drawn_r  <= drawn;
      frame_r  <= frame_w;
      dx_r     <= dx_w;
      dy_r     <= dy_w;
      full_r   <= head.full;
      active_r <= (head.mode != twt_pkg::MODE_IDLE);
    end
  end

  assign out_valid       = valid_r;
  assign out_tile_drawn  = drawn_r;
  assign out_tile_frame  = frame_r;
  assign out_draw_x      = dx_r;
  assign out_draw_y      = dy_r;
  assign out_mask_full   = full_r;
  assign out_fade_active = active_r;

endmodule

[hdl/tile_wipe_transition.sv]
// Tile wipe transition top level: config registers, front, queue, back.
// An accepted word is queued, then popped into the back's result word for out_valid.
// Throughput: one word per cycle unless out_ready stalls; in_ready drops only on a full queue.
// Reset (synchronous, rst_n low): fade idle, tick and mask clear, out_valid low, queue empty,
// screen size 320 x 240. Depends on twt_pkg, twt_front, twt_queue, twt_back.
`timescale 1ns / 1ps

module tile_wipe_transition #(
  parameter int FADE_FRAMES = twt_pkg::FADE_FRAMES_DEF,
  parameter int QUEUE_DEPTH = twt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_addr,
  input  logic [11:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [1:0]         in_start_mode,
  input  logic [2:0]         in_start_dir,
  input  logic [8:0]         in_tile_x,
  input  logic [8:0]         in_tile_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_tile_drawn,
  output logic [3:0]         out_tile_frame,
  output logic signed [13:0] out_draw_x,
  output logic signed [13:0] out_draw_y,
  output logic               out_mask_full,
  output logic               out_fade_active
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [11:0]     width_r, height_r;
  logic            q_full, q_empty, push, pop;
  logic [CW-1:0]   q_count;
  twt_pkg::entry_t push_data, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd320;
      height_r <= 12'd240;
    end else if (cfg_we) begin
      case (cfg_addr)
        twt_pkg::REG_WIDTH:  width_r  <= cfg_wdata;
        twt_pkg::REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  twt_front #(.FADE_FRAMES(FADE_FRAMES)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .screen_width  (width_r),
    .screen_height (height_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_start_mode (in_start_mode),
    .in_start_dir  (in_start_dir),
    .in_tile_x     (in_tile_x),
    .in_tile_y     (in_tile_y),
    .q_full        (q_full),
    .push          (push),
    .push_data     (push_data)
  );

  twt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full),
    .count     (q_count)
  );

  twt_back #(.FADE_FRAMES(FADE_FRAMES)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .screen_width    (width_r),
    .screen_height   (height_r),
    .q_empty         (q_empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tile_drawn  (out_tile_drawn),
    .out_tile_frame  (out_tile_frame),
    .out_draw_x      (out_draw_x),
    .out_draw_y      (out_draw_y),
    .out_mask_full   (out_mask_full),
    .out_fade_active (out_fade_active)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count == CW'(QUEUE_DEPTH)) |-> !in_ready)
    else $error("ready while queue full");

  a_drawn_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tile_drawn) |-> (out_tile_frame != 4'd0))
    else $error("drawn tile with frame zero");

  a_mask_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_mask_full && out_fade_active))
    else $error("full cover reported during a fade");

endmodule

[tb/tb.sv]
// Self-checking testbench for tile_wipe_transition: random fades, ticks and tile queries
// checked against an in-bench prediction of the wipe state. Depends on twt_pkg and tile_wipe_transition.
`timescale 1ns / 1ps

module tb;

  localparam int FADES = twt_pkg::FADE_FRAMES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam int NUM_PHASES = 7;
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [1:0] MODE_BAD = 2'd3;
  localparam logic [2:0] DIR_BAD = 3'd7;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] mode;
    logic [2:0] dir;
    logic [8:0] x;
    logic [8:0] y;
  } word_t;

  typedef struct {
    logic              drawn;
    logic [3:0]        frame;
    logic signed [13:0] dx;
    logic signed [13:0] dy;
    logic              full;
    logic              active;
  } tile_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_addr = twt_pkg::REG_WIDTH;
  logic [11:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = '0;
  logic [1:0] in_start_mode = '0;
  logic [2:0] in_start_dir = '0;
  logic [8:0] in_tile_x = '0;
  logic [8:0] in_tile_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_tile_drawn;
  logic [3:0] out_tile_frame;
  logic signed [13:0] out_draw_x;
  logic signed [13:0] out_draw_y;
  logic out_mask_full;
  logic out_fade_active;

  tile_wipe_transition u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_start_mode(in_start_mode), .in_start_dir(in_start_dir),
    .in_tile_x(in_tile_x), .in_tile_y(in_tile_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_tile_drawn(out_tile_drawn), .out_tile_frame(out_tile_frame),
    .out_draw_x(out_draw_x), .out_draw_y(out_draw_y),
    .out_mask_full(out_mask_full), .out_fade_active(out_fade_active)
  );

  always #10 clk = ~clk;

  // predicted wipe state and screen size
  logic [11:0] scr_w = 12'd320;
  logic [11:0] scr_h = 12'd240;
  logic [1:0] wipe_mode = twt_pkg::MODE_IDLE;
  logic [2:0] wipe_dir = twt_pkg::DIR_LEFT;
  logic [8:0] wipe_tick = '0;
  logic wipe_full = 1'b0;

  word_t pending[$];
  tile_res_t tile_exp_q[$];
  word_t bus_word;
  tile_res_t mon_exp;

  int errors = 0;
  int n_checked = 0;
  int n_queries = 0;
  int n_drawn = 0;
  int n_fade_end = 0;
  int n_sizes = 1;
  int src_idle = 6;
  int snk_idle = 81;
  int cycles = 0;
  int hold_left = 0;
  bit hold_arm = 1'b0;
  bit hold_done = 1'b0;

  function automatic tile_res_t wipe_predict(word_t wd);
    tile_res_t r;
    int frames, w, h, c, d, f, x, y, rem, px, py;
    bit ok;
    r = '{default: 0};
    x = int'(wd.x);
    y = int'(wd.y);
    frames = int'(((scr_w > scr_h) ? scr_w : scr_h) / 16) + FADES;
    w = int'(scr_w / 16) + 1;
    h = int'(scr_h / 16) + 1;
    case (wd.kind)
      twt_pkg::KIND_START: begin
        if (wd.mode == twt_pkg::MODE_IN || wd.mode == twt_pkg::MODE_OUT) begin
          wipe_mode = wd.mode;
          wipe_dir = wd.dir;
          wipe_tick = '0;
          wipe_full = 1'b0;
        end
      end
      twt_pkg::KIND_TICK: begin
        if (wipe_mode != twt_pkg::MODE_IDLE) begin
          wipe_full = 1'b0;
          wipe_tick = wipe_tick + 9'd1;
          if (int'(wipe_tick) > frames) begin
            wipe_full = (wipe_mode == twt_pkg::MODE_OUT);
            wipe_mode = twt_pkg::MODE_IDLE;
            n_fade_end++;
          end
        end
      end
      twt_pkg::KIND_QUERY: begin
        n_queries++;
        c = int'(wipe_tick);
        d = ((x > int'(scr_w >> 5)) ? x - int'(scr_w >> 5) : int'(scr_w >> 5) - x)
          + ((y > int'(scr_h >> 5)) ? y - int'(scr_h >> 5) : int'(scr_h >> 5) - y);
        ok = !wipe_full && x < w && y < h && wipe_dir <= twt_pkg::DIR_DIAMOND;
        f = 0;
        rem = frames - c;
        if (ok && wipe_mode == twt_pkg::MODE_IN) begin
          case (wipe_dir)
            twt_pkg::DIR_LEFT:  f = rem - x;
            twt_pkg::DIR_UP:    f = rem - y;
            twt_pkg::DIR_RIGHT: f = x - (w - rem);
            twt_pkg::DIR_DOWN:  f = y - (h - rem);
            default:            f = FADES - (c - d);
          endcase
        end else if (ok && wipe_mode == twt_pkg::MODE_OUT) begin
          case (wipe_dir)
            twt_pkg::DIR_LEFT:  f = x - (w - c);
            twt_pkg::DIR_UP:    f = y - (h - c);
            twt_pkg::DIR_RIGHT: f = c - x;
            twt_pkg::DIR_DOWN:  f = c - y;
            default:            f = FADES - (rem - d);
          endcase
        end
        if (f > 0) begin
          if (f > FADES - 1) f = FADES - 1;
          if (f > 15) f = 15;
          px = x * 16 - (w * 16 - int'(scr_w));
          py = y * 16 - (h * 16 - int'(scr_h));
          r.drawn = 1'b1;
          r.frame = f[3:0];
          r.dx = px[13:0];
          r.dy = py[13:0];
          n_drawn++;
        end
      end
      default: ;
    endcase
    r.full = wipe_full;
    r.active = (wipe_mode != twt_pkg::MODE_IDLE);
    return r;
  endfunction

  task automatic cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic push_word(input logic [1:0] k, input logic [1:0] m, input logic [2:0] dr,
                           input logic [8:0] x, input logic [8:0] y);
    word_t wd;
    wd.kind = k;
    wd.mode = m;
    wd.dir = dr;
    wd.x = x;
    wd.y = y;
    pending.push_back(wd);
  endtask

  function automatic logic [8:0] pick_coord(input int lim);
    int r;
    r = $urandom_range(9);
    if (r < 7) return 9'($urandom_range(0, lim));
    if (r < 8) return 9'(lim - 1);
    return 9'($urandom_range(0, 511));
  endfunction

  // mostly complete fades with random ticks and queries, some noise words
  task automatic gen_random(input int n);
    int cnt, frames, w, h, ticks, pt;
    frames = int'(((scr_w > scr_h) ? scr_w : scr_h) / 16) + FADES;
    w = int'(scr_w / 16) + 1;
    h = int'(scr_h / 16) + 1;
    pt = (frames > 100) ? 70 : 40;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(99) < 85) begin
        push_word(twt_pkg::KIND_START, 2'($urandom_range(1, 2)),
                  ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4)),
                  9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
        cnt++;
        ticks = 0;
        while (ticks <= frames + 1 && cnt < n) begin
          if ($urandom_range(99) < pt) begin
            push_word(twt_pkg::KIND_TICK, 2'($urandom_range(0, 3)),
                      3'($urandom_range(0, 7)),
                      9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
            ticks++;
          end else begin
            push_word(twt_pkg::KIND_QUERY, 2'($urandom_range(0, 3)),
                      3'($urandom_range(0, 7)), pick_coord(w), pick_coord(h));
          end
          cnt++;
          if ($urandom_range(399) == 0) break;
        end
      end else begin
        push_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                  9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
        cnt++;
      end
    end
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [11:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    if (idx == twt_pkg::REG_WIDTH) scr_w = val;
    else scr_h = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending.size() != 0 || in_valid || tile_exp_q.size() != 0) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        tile_exp_q.push_back(wipe_predict(bus_word));
      end
      if (!in_valid || in_ready) begin
        if (pending.size() != 0 && $urandom_range(99) >= src_idle) begin
          bus_word = pending.pop_front();
          in_valid <= 1'b1;
          in_kind <= bus_word.kind;
          in_start_mode <= bus_word.mode;
          in_start_dir <= bus_word.dir;
          in_tile_x <= bus_word.x;
          in_tile_y <= bus_word.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (tile_exp_q.size() == 0) begin
          $display("%0t: result word with nothing expected", $time);
          errors++;
        end else begin
          mon_exp = tile_exp_q.pop_front();
          cmp_field("tile_drawn", int'(mon_exp.drawn), int'(out_tile_drawn));
          cmp_field("tile_frame", int'(mon_exp.frame), int'(out_tile_frame));
          cmp_field("draw_x", int'(mon_exp.dx), int'(out_draw_x));
          cmp_field("draw_y", int'(mon_exp.dy), int'(out_draw_y));
          cmp_field("mask_full", int'(mon_exp.full), int'(out_mask_full));
          cmp_field("fade_active", int'(mon_exp.active), int'(out_fade_active));
          n_checked++;
        end
      end
      if (hold_arm && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tile_wipe_transition test failed");
      $finish;
    end
  end

  initial begin
    int ph_w[NUM_PHASES];
    int ph_h[NUM_PHASES];
    int ph_n[NUM_PHASES];
    ph_w = '{320, 16, 4095, 4095, 16, 0, 0};
    ph_h = '{240, 16, 4095, 16, 4095, 0, 0};
    ph_n = '{200, 200, 300, 100, 100, 75, 75};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // status on idle, ignored words, grid edges, clamped diamond, odd direction
    push_word(twt_pkg::KIND_QUERY, twt_pkg::MODE_IDLE, twt_pkg::DIR_LEFT, 9'd0, 9'd0);
    push_word(twt_pkg::KIND_QUERY, MODE_BAD, DIR_BAD, 9'd511, 9'd511);
    push_word(KIND_NONE, twt_pkg::MODE_IN, twt_pkg::DIR_UP, 9'd3, 9'd3);
    push_word(twt_pkg::KIND_START, twt_pkg::MODE_IDLE, twt_pkg::DIR_LEFT, 9'd0, 9'd0);
    push_word(twt_pkg::KIND_START, MODE_BAD, twt_pkg::DIR_RIGHT, 9'd0, 9'd0);
    push_word(twt_pkg::KIND_TICK, twt_pkg::MODE_IDLE, twt_pkg::DIR_LEFT, 9'd0, 9'd0);
    push_word(twt_pkg::KIND_START, twt_pkg::MODE_IN, twt_pkg::DIR_LEFT, 9'd0, 9'd0);
    push_word(twt_pkg::KIND_QUERY, twt_pkg::MODE_IDLE, twt_pkg::DIR_LEFT, 9'd0, 9'd0);
    push_word(twt_pkg::KIND_QUERY, twt_pkg::MODE_IDLE, twt_pkg::DIR_LEFT, 9'd20, 9'd15);
    push_word(twt_pkg::KIND_QUERY, twt_pkg::MODE_IDLE, twt_pkg::DIR_LEFT, 9'd21, 9'd0);
    push_word(twt_pkg::KIND_QUERY, twt_pkg::MODE_IDLE, twt_pkg::DIR_LEFT, 9'd0, 9'd16);
    push_word(twt_pkg::KIND_TICK, twt_pkg::MODE_IDLE, twt_pkg::DIR_LEFT, 9'd0, 9'd0);
    push_word(twt_pkg::KIND_QUERY, twt_pkg::MODE_IDLE, twt_pkg::DIR_LEFT, 9'd19, 9'd3);
    push_word(twt_pkg::KIND_START, twt_pkg::MODE_IN, twt_pkg::DIR_DIAMOND, 9'd0, 9'd0);
    push_word(twt_pkg::KIND_QUERY, twt_pkg::MODE_IDLE, twt_pkg::DIR_LEFT, 9'd10, 9'd7);
    push_word(twt_pkg::KIND_QUERY, twt_pkg::MODE_IDLE, twt_pkg::DIR_LEFT, 9'd0, 9'd0);
    push_word(twt_pkg::KIND_START, twt_pkg::MODE_OUT, twt_pkg::DIR_RIGHT, 9'd0, 9'd0);
    push_word(twt_pkg::KIND_TICK, twt_pkg::MODE_IDLE, twt_pkg::DIR_LEFT, 9'd0, 9'd0);
    push_word(twt_pkg::KIND_TICK, twt_pkg::MODE_IDLE, twt_pkg::DIR_LEFT, 9'd0, 9'd0);
    push_word(twt_pkg::KIND_QUERY, twt_pkg::MODE_IDLE, twt_pkg::DIR_LEFT, 9'd1, 9'd0);
    push_word(twt_pkg::KIND_QUERY, twt_pkg::MODE_IDLE, twt_pkg::DIR_LEFT, 9'd2, 9'd0);
    push_word(twt_pkg::KIND_START, twt_pkg::MODE_OUT, DIR_BAD, 9'd0, 9'd0);
    push_word(twt_pkg::KIND_TICK, twt_pkg::MODE_IDLE, twt_pkg::DIR_LEFT, 9'd0, 9'd0);
    push_word(twt_pkg::KIND_QUERY, twt_pkg::MODE_IDLE, twt_pkg::DIR_LEFT, 9'd0, 9'd0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        repeat (3) @(posedge clk);
        if (ph_w[ph] == 0) begin
          ph_w[ph] = $urandom_range(16, 600);
          ph_h[ph] = $urandom_range(16, 600);
        end
        write_reg(twt_pkg::REG_WIDTH, 12'(ph_w[ph]));
        write_reg(twt_pkg::REG_HEIGHT, 12'(ph_h[ph]));
        n_sizes++;
        @(negedge clk);
      end
      src_idle = (ph < 2) ? 6 : (ph < 4) ? 81 : 0;
      snk_idle = (ph < 2) ? 81 : (ph < 4) ? 6 : 0;
      if (ph == 4) hold_arm = 1'b1;
      gen_random(ph_n[ph]);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (tile_exp_q.size() != 0) begin
      $display("%0d expected results never arrived", tile_exp_q.size());
      errors++;
    end
    $display("%0d words checked over %0d screen sizes, %0d fades run to the end",
             n_checked, n_sizes, n_fade_end);
    $display("%0d tile queries, %0d of them drawn, %0d mismatches", n_queries, n_drawn, errors);
    if (errors == 0) begin
      $display("tile_wipe_transition test passed");
    end else begin
      $display("tile_wipe_transition test failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/twt_pkg.sv
hdl/twt_queue.sv
hdl/twt_front.sv
hdl/twt_back.sv
hdl/tile_wipe_transition.sv
tb/tb.sv
